### src/trimmed_mean_edge_detector_top_macros.svh
// Assertion macros for the trimmed-mean edge detector checker.
// Self-contained: no other file is needed by this header.
`ifndef TRIMMED_MEAN_EDGE_DETECTOR_TOP_MACROS_SVH
`define TRIMMED_MEAN_EDGE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TMED_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TMED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tmed_pkg.sv
// Shared constants for the trimmed-mean edge detector.
// Used by the top level and by the port checker; depends on nothing.
`timescale 1ns / 1ps

package tmed_pkg;

  // Window geometry
  localparam int WIN_LEN = 5;
  localparam int DIV_LEN = WIN_LEN - 2;
  localparam int SLOT_W  = $clog2(WIN_LEN);

  // Field widths
  localparam int DATA_W  = 16;
  localparam int ANGLE_W = 9;
  localparam int EDGE_W  = 2;

  // Arithmetic widths: full sum, sum without extremes
  localparam int SUM_W  = DATA_W + $clog2(WIN_LEN);
  localparam int TRIM_W = DATA_W + ((DIV_LEN > 1) ? $clog2(DIV_LEN) : 1);

  // Reciprocal for the divide by DIV_LEN: exact for any TRIM_W-bit dividend
  localparam int RECIP_SHIFT = TRIM_W + $clog2(DIV_LEN);
  localparam int RECIP_W     = TRIM_W + 1;
  localparam int PROD_W      = TRIM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(DIV_LEN) - 64'd1) / 64'(DIV_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  // Register reset: 50 cm in 12.4 fixed point
  localparam logic [DATA_W-1:0] CUTOFF_RST = 16'd800;

  // Sample kinds
  localparam logic KIND_PRIME = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  // Edge codes
  localparam logic [EDGE_W-1:0] EDGE_NONE  = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_START = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_END   = 2'd2;

endpackage

### src/trimmed_mean_edge_detector_top.sv
// Trimmed-mean distance filter with near/far edge detection. Takes one
// transaction per clock while in_stall is low: each sample is written into a
// five-entry circular window at the accept edge, and a scan sample's result
// (window mean without one smallest and one largest entry, near flag, edge
// code and angle) appears on out_valid after the min/max-and-sum stage, the
// reciprocal-multiply divide stage and the threshold/edge stage. Priming
// samples fill the window, clear the remembered detection and give no result.
// The pipeline moves one transaction per cycle whenever the output is not
// stalled; in_stall rises only when every stage holds a transaction and the
// output register is stalled. The cutoff register may be written only while
// no transaction is in flight. Reset clears the window.
// Depends on tmed_pkg.
`timescale 1ns / 1ps

module trimmed_mean_edge_detector_top
  import tmed_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [DATA_W-1:0]  in_sample,
  input  logic [ANGLE_W-1:0] in_angle,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_filtered,
  output logic               out_near,
  output logic [EDGE_W-1:0]  out_edge_res,
  output logic [ANGLE_W-1:0] out_edge_angle,
  // configuration
  input  logic               cfg_we,
  input  logic [DATA_W-1:0]  cfg_wdata
);

  // Window and slot pointer
  logic [DATA_W-1:0]  window_r [WIN_LEN];
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [DATA_W-1:0]  cutoff_r;

  // Stage 1: window holds the item, side fields here
  logic               s1_vld_r, s1_vld_nxt;
  logic               s1_kind_r;
  logic [ANGLE_W-1:0] s1_angle_r;

  // Stage 2: sum and extremes
  logic               s2_vld_r, s2_vld_nxt;
  logic               s2_kind_r;
  logic [ANGLE_W-1:0] s2_angle_r;
  logic [SUM_W-1:0]   s2_sum_r;
  logic [DATA_W-1:0]  s2_lo_r;
  logic [DATA_W-1:0]  s2_hi_r;

  // Stage 3: trimmed mean
  logic               s3_vld_r, s3_vld_nxt;
  logic               s3_kind_r;
  logic [ANGLE_W-1:0] s3_angle_r;
  logic [DATA_W-1:0]  s3_mean_r;

  // Output stage
  logic               out_vld_r, out_vld_nxt;
  logic [DATA_W-1:0]  out_filtered_r;
  logic               out_near_r;
  logic [EDGE_W-1:0]  out_edge_r;
  logic [ANGLE_W-1:0] out_angle_r;
  logic               was_near_r, was_near_nxt;

  // Flow control
  logic in_accept;
  logic out_ready;
  logic s3_go, s3_ready;
  logic s2_go, s2_ready;
  logic s1_go, s1_ready;

  // Combinational results
  logic [SUM_W-1:0]   sum_c;
  logic [DATA_W-1:0]  lo_c;
  logic [DATA_W-1:0]  hi_c;
  logic [TRIM_W-1:0]  trim_c;
  logic [PROD_W-1:0]  prod_c;
  logic               near_c;
  logic [EDGE_W-1:0]  edge_c;

  // Backpressure chain, output side first; priming needs no output slot
  assign out_ready = !out_vld_r || !out_stall;
  assign s3_go     = s3_vld_r && ((s3_kind_r == KIND_PRIME) || out_ready);
  assign s3_ready  = !s3_vld_r || s3_go;
  assign s2_go     = s2_vld_r && s3_ready;
  assign s2_ready  = !s2_vld_r || s3_ready;
  assign s1_go     = s1_vld_r && s2_ready;
  assign s1_ready  = !s1_vld_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  // Slot pointer wraps at the window length
  assign slot_nxt = (slot_r == SLOT_W'(WIN_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);

  // Valid bits
  always_comb begin
    s1_vld_nxt = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_vld_r);
    s2_vld_nxt = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_vld_r);
    s3_vld_nxt = s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_vld_r);
    if (s3_go && (s3_kind_r == KIND_SCAN)) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Window write and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        window_r[i] <= '0;
      end
      slot_r   <= '0;
      cutoff_r <= CUTOFF_RST;
    end else begin
      if (in_accept) begin
        window_r[slot_r] <= in_sample;
        slot_r           <= slot_nxt;
      end
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      was_near_r <= 1'b0;
    end else begin
      s1_vld_r   <= s1_vld_nxt;
      s2_vld_r   <= s2_vld_nxt;
      s3_vld_r   <= s3_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      was_near_r <= was_near_nxt;
    end
  end

  // Sum and extremes of the window; ties drop exactly one entry each way
  always_comb begin
    sum_c = '0;
    lo_c  = window_r[0];
    hi_c  = window_r[0];
    for (int i = 0; i < WIN_LEN; i++) begin
      sum_c = sum_c + SUM_W'(window_r[i]);
      if (window_r[i] < lo_c) begin
        lo_c = window_r[i];
      end
      if (window_r[i] > hi_c) begin
        hi_c = window_r[i];
      end
    end
  end

  // Divide by the trimmed count through a reciprocal multiply
  assign trim_c = TRIM_W'(s2_sum_r - SUM_W'(s2_lo_r) - SUM_W'(s2_hi_r));
  assign prod_c = PROD_W'(trim_c) * PROD_W'(RECIP);

  // Threshold and edge against the previous scan sample
  assign near_c = s3_mean_r < cutoff_r;

  always_comb begin
    if (near_c && !was_near_r) begin
      edge_c = EDGE_START;
    end else if (!near_c && was_near_r) begin
      edge_c = EDGE_END;
    end else begin
      edge_c = EDGE_NONE;
    end
  end

  // Priming clears the detection; a scan sample records its own
  always_comb begin
    was_near_nxt = was_near_r;
    if (s3_go) begin
      was_near_nxt = (s3_kind_r == KIND_SCAN) ? near_c : 1'b0;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r  <= in_kind;
      s1_angle_r <= in_angle;
    end
    if (s1_go) begin
      s2_kind_r  <= s1_kind_r;
      s2_angle_r <= s1_angle_r;
      s2_sum_r   <= sum_c;
      s2_lo_r    <= lo_c;
      s2_hi_r    <= hi_c;
    end
    if (s2_go) begin
      s3_kind_r  <= s2_kind_r;
      s3_angle_r <= s2_angle_r;
      s3_mean_r  <= prod_c[RECIP_SHIFT +: DATA_W];
    end
    if (s3_go && (s3_kind_r == KIND_SCAN)) begin
      out_filtered_r <= s3_mean_r;
      out_near_r     <= near_c;
      out_edge_r     <= edge_c;
      out_angle_r    <= (edge_c != EDGE_NONE) ? s3_angle_r : '0;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_filtered   = out_filtered_r;
  assign out_near       = out_near_r;
  assign out_edge_res   = out_edge_r;
  assign out_edge_angle = out_angle_r;

endmodule

### src/tmed_checker.sv
// Port-level checker for the trimmed-mean edge detector, bound to the top.
// Depends on tmed_pkg and trimmed_mean_edge_detector_top_macros.svh.
`timescale 1ns / 1ps
`include "trimmed_mean_edge_detector_top_macros.svh"

module tmed_checker
  import tmed_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DATA_W-1:0]  out_filtered,
  input logic               out_near,
  input logic [EDGE_W-1:0]  out_edge_res,
  input logic [ANGLE_W-1:0] out_edge_angle
);

  // A stalled result transaction stays offered
  `TMED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

  // A stalled result transaction keeps its mean
  `TMED_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_filtered), "out_filtered changed while stalled")

  // An object start means the result is near
  `TMED_ASSERT_SAME(a_start_near, clk, rst_n, out_valid && (out_edge_res == EDGE_START), out_near, "start edge without near")

  // An object end means the result is not near
  `TMED_ASSERT_SAME(a_end_far, clk, rst_n, out_valid && (out_edge_res == EDGE_END), !out_near, "end edge while near")

  // No edge carries no angle
  `TMED_ASSERT_SAME(a_none_angle, clk, rst_n, out_valid && (out_edge_res == EDGE_NONE), out_edge_angle == '0, "angle set without edge")

endmodule

bind trimmed_mean_edge_detector_top tmed_checker u_tmed_checker (.*);

### bench/tb_trimmed_mean_edge_detector_top.sv
// Testbench for trimmed_mean_edge_detector_top: directed corners, then random
// priming/scan sequences checked against an in-bench window and edge predictor.
// Depends on tmed_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_trimmed_mean_edge_detector_top;
  import tmed_pkg::*;

  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 100;

  // Expected output of one scan transaction
  typedef struct packed {
    logic [DATA_W-1:0]  filtered;
    logic               near;
    logic [EDGE_W-1:0]  edge_res;
    logic [ANGLE_W-1:0] edge_angle;
  } scan_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic [DATA_W-1:0]  in_sample;
  logic [ANGLE_W-1:0] in_angle;
  logic               out_valid;
  logic               out_stall;
  logic [DATA_W-1:0]  out_filtered;
  logic               out_near;
  logic [EDGE_W-1:0]  out_edge_res;
  logic [ANGLE_W-1:0] out_edge_angle;
  logic               cfg_we;
  logic [DATA_W-1:0]  cfg_wdata;

  // Predictor state
  logic [DATA_W-1:0]  win_model [WIN_LEN];
  int                 slot_model;
  logic               was_near_model;
  logic [DATA_W-1:0]  cutoff_model;

  scan_result_t       pending_results[$];
  int                 error_count;
  int                 gap_max;
  int                 stall_max;
  int                 stall_hold;

  trimmed_mean_edge_detector_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_sample      (in_sample),
    .in_angle       (in_angle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_filtered   (out_filtered),
    .out_near       (out_near),
    .out_edge_res   (out_edge_res),
    .out_edge_angle (out_edge_angle),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mean of the window with one smallest and one largest entry removed
  function automatic logic [DATA_W-1:0] window_trimmed_mean();
    logic [31:0]       total;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    total = '0;
    lo = win_model[0];
    hi = win_model[0];
    for (int k = 0; k < WIN_LEN; k++) begin
      total += 32'(win_model[k]);
      if (win_model[k] < lo) lo = win_model[k];
      if (win_model[k] > hi) hi = win_model[k];
    end
    total = total - 32'(lo) - 32'(hi);
    return DATA_W'(total / 32'(DIV_LEN));
  endfunction

  // Input monitor: register writes and accepted transactions drive the predictor
  always @(posedge clk) begin
    scan_result_t      res;
    logic [DATA_W-1:0] mean;
    logic              now_near;
    if (!rst_n) begin
      for (int k = 0; k < WIN_LEN; k++) win_model[k] = '0;
      slot_model     = 0;
      was_near_model = 1'b0;
      cutoff_model   = CUTOFF_RST;
    end else begin
      if (cfg_we) cutoff_model = cfg_wdata;
      if (in_valid && !in_stall) begin
        win_model[slot_model] = in_sample;
        slot_model = (slot_model + 1 >= WIN_LEN) ? 0 : slot_model + 1;
        if (in_kind == KIND_PRIME) begin
          was_near_model = 1'b0;
        end else begin
          mean     = window_trimmed_mean();
          now_near = mean < cutoff_model;
          res.filtered = mean;
          res.near     = now_near;
          if (now_near && !was_near_model) res.edge_res = EDGE_START;
          else if (!now_near && was_near_model) res.edge_res = EDGE_END;
          else res.edge_res = EDGE_NONE;
          res.edge_angle = (res.edge_res != EDGE_NONE) ? in_angle : '0;
          was_near_model = now_near;
          pending_results.push_back(res);
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    begin
      if (error_count < MAX_REPORTS)
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      error_count++;
    end
  endtask

  // Result checker; each accepted result also draws the next stall length
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, filtered", int'(out_filtered), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_filtered !== want.filtered)
          report_mismatch("filtered", int'(out_filtered), int'(want.filtered));
        if (out_near !== want.near)
          report_mismatch("near", int'(out_near), int'(want.near));
        if (out_edge_res !== want.edge_res)
          report_mismatch("edge_res", int'(out_edge_res), int'(want.edge_res));
        if (out_edge_angle !== want.edge_angle)
          report_mismatch("edge_angle", int'(out_edge_angle), int'(want.edge_angle));
      end
      stall_hold = $urandom_range(0, stall_max);
    end
  end

  // Output stall driver
  always @(negedge clk) begin
    if (rst_n && stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Drive one transaction and wait until it is accepted
  task automatic send_sample(input logic kind, input logic [DATA_W-1:0] smp,
                             input logic [ANGLE_W-1:0] ang);
    int gap;
    begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
      @(negedge clk);
      in_valid  <= 1'b1;
      in_kind   <= kind;
      in_sample <= smp;
      in_angle  <= ang;
      do @(posedge clk); while (!(in_valid && !in_stall));
    end
  endtask

  // Let every expected result come out, then allow for in-flight priming items
  task automatic wait_idle();
    begin
      @(negedge clk) in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_cutoff(input logic [DATA_W-1:0] value);
    begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= value;
      @(negedge clk) cfg_we <= 1'b0;
    end
  endtask

  // Mix of idle patterns: full random, none, one side only
  task automatic pick_pace();
    int mode;
    begin
      mode = $urandom_range(0, 3);
      gap_max   = (mode == 0 || mode == 2) ? 15 : 0;
      stall_max = (mode == 0 || mode == 3) ? 15 : 0;
    end
  endtask

  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(0, 9) == 0) return ANGLE_W'($urandom_range(0, 511));
    return ANGLE_W'($urandom_range(0, 359));
  endfunction

  // Sample on one side of the cutoff, clamped to the field range
  function automatic logic [DATA_W-1:0] pick_sample(input bit below);
    int v;
    if (below) v = int'(cutoff_model) - int'($urandom_range(1, 600));
    else v = int'(cutoff_model) + int'($urandom_range(0, 600));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DATA_W'(v);
  endfunction

  function automatic logic [DATA_W-1:0] pick_wild_sample();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Corners right after reset with the default cutoff
  task automatic test_directed_corners();
    begin
      gap_max   = 0;
      stall_max = 0;
      send_sample(KIND_SCAN, 16'd0, 9'd17);        // zero window: object starts
      send_sample(KIND_SCAN, 16'hFFFF, 9'd359);    // one extreme dropped
      send_sample(KIND_SCAN, 16'hFFFF, 9'd0);
      send_sample(KIND_SCAN, 16'hFFFF, 9'd511);    // still far: no edge, wild angle
      repeat (5) send_sample(KIND_PRIME, 16'hFFFF, 9'd0);
      send_sample(KIND_SCAN, 16'hFFFF, 9'd256);    // all equal at maximum
      repeat (4) send_sample(KIND_PRIME, 16'd0, 9'd0);
      send_sample(KIND_SCAN, 16'd0, 9'd360);       // all zero: starts, angle out of range
      send_sample(KIND_PRIME, 16'd799, 9'd255);    // priming clears the detection
      send_sample(KIND_SCAN, 16'd799, 9'd170);     // starts again
      send_sample(KIND_SCAN, 16'd800, 9'd85);
      send_sample(KIND_SCAN, 16'd800, 9'd341);
      send_sample(KIND_SCAN, 16'd800, 9'd1);       // mean just below cutoff: still near
      send_sample(KIND_SCAN, 16'h5555, 9'd2);
      send_sample(KIND_SCAN, 16'hAAAA, 9'd4);
      gap_max   = 15;
      stall_max = 15;
      send_sample(KIND_SCAN, 16'd1, 9'd128);
      send_sample(KIND_PRIME, 16'd0, 9'd0);
      send_sample(KIND_SCAN, 16'd2, 9'd64);
      wait_idle();
    end
  endtask

  // Random transactions under extreme cutoff settings
  task automatic test_cutoff_extremes();
    logic [DATA_W-1:0] cutoffs [4];
    begin
      cutoffs = '{16'd0, 16'hFFFF, 16'd1, CUTOFF_RST};
      foreach (cutoffs[p]) begin
        write_cutoff(cutoffs[p]);
        for (int n = 0; n < 100; n++) begin
          if (n % 25 == 0) pick_pace();
          if ($urandom_range(0, 1) == 0)
            send_sample(($urandom_range(0, 4) == 0) ? KIND_PRIME : KIND_SCAN,
                        pick_wild_sample(), pick_angle());
          else
            send_sample(KIND_SCAN, pick_sample($urandom_range(0, 1) == 1), pick_angle());
        end
        wait_idle();
      end
    end
  endtask

  // Priming bursts followed by scan runs that cross the cutoff both ways
  task automatic test_object_scans();
    int sent;
    int run_len;
    int hold;
    bit target_near;
    begin
      for (int p = 0; p < 5; p++) begin
        write_cutoff(DATA_W'($urandom_range(100, 65000)));
        sent = 0;
        while (sent < 235) begin
          pick_pace();
          if ($urandom_range(0, 9) == 0) begin
            // noise transaction
            send_sample(($urandom_range(0, 1) == 1) ? KIND_SCAN : KIND_PRIME,
                        pick_wild_sample(), pick_angle());
            sent++;
          end else begin
            repeat ($urandom_range(0, WIN_LEN + 2)) begin
              send_sample(KIND_PRIME, pick_sample($urandom_range(0, 1) == 1), pick_angle());
              sent++;
            end
            run_len     = $urandom_range(4, 30);
            target_near = ($urandom_range(0, 1) == 1);
            hold        = $urandom_range(3, 12);
            for (int k = 0; k < run_len; k++) begin
              if (hold == 0) begin
                target_near = !target_near;
                hold = $urandom_range(3, 12);
              end
              hold--;
              send_sample(KIND_SCAN, pick_sample(target_near), pick_angle());
              sent++;
            end
          end
        end
        wait_idle();
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = KIND_PRIME;
    in_sample   = '0;
    in_angle    = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    error_count = 0;
    gap_max     = 0;
    stall_max   = 0;
    stall_hold  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed_corners();
    test_cutoff_extremes();
    test_object_scans();

    if (error_count == 0) begin
      $display("tb_trimmed_mean_edge_detector_top: clean");
    end else begin
      $display("tb_trimmed_mean_edge_detector_top: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_trimmed_mean_edge_detector_top: errors");
    $finish;
  end

endmodule
